// ===== hw/rtl/sapl_pkg.sv =====
// Shared types and constants for the sorted address predecessor lookup block.
package sapl_pkg;

   // Field widths of the request and response words.
   localparam int SAPL_ADDR_W  = 64;
   localparam int SAPL_INDEX_W = 16;
   localparam int SAPL_LEN_W   = 17;

   // Largest number of entries that a search can cover, set by the index field.
   localparam int SAPL_INDEX_SPAN = 65536;

   // Default number of table entries.
   localparam int SAPL_TABLE_DEPTH = 65536;

   // Request modes.
   localparam logic SAPL_MODE_LOAD  = 1'b0;
   localparam logic SAPL_MODE_QUERY = 1'b1;

   // One request word.
   typedef struct packed {
      logic                    mode;
      logic [SAPL_INDEX_W-1:0] entry_index;
      logic [SAPL_ADDR_W-1:0]  entry_address;
      logic [SAPL_ADDR_W-1:0]  query_address;
   } req_word_type;

   // One response word.
   typedef struct packed {
      logic [SAPL_INDEX_W-1:0] symbol_index;
      logic [SAPL_ADDR_W-1:0]  offset;
      logic                    below_first;
   } rsp_word_type;

endpackage

// ===== hw/rtl/sapl_table.sv =====
// Single-port-write, single-port-read address table with registered read data.
module sapl_table #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data is held until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sorted_address_predecessor_lookup.sv =====
// Top level of the sorted address predecessor lookup block.

// A load word writes one 64-bit start address into the table in the cycle it
// is accepted; loads with an index at or beyond the table depth are dropped.
// A query word runs a binary search over the first table_length entries
// (clamped to the depth and to 65536), which software keeps in ascending
// order, and returns the index of the greatest entry at or below the query,
// the offset from it, and a flag when no entry qualifies. Table contents are
// undefined until written; there is no clearing pass after reset. The search
// shares one table read port and one 64-bit comparator: each probe is a table
// read, then a compare. The block stalls requests while a query is under way,
// and the last step of a query waits as long as the previous response word is
// stalled.
module sorted_address_predecessor_lookup
   import sapl_pkg::*;
#(
   parameter int TABLE_DEPTH = SAPL_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SAPL_LEN_W-1:0] csr_data
);

   localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW      = (AW > SAPL_LEN_W) ? AW : SAPL_LEN_W;
   localparam int MAX_LEN = (TABLE_DEPTH < SAPL_INDEX_SPAN) ? TABLE_DEPTH : SAPL_INDEX_SPAN;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_PICK,
      ST_PICK_DATA,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [SAPL_LEN_W-1:0]  len_ff, len_in;
   logic [SAPL_LEN_W-1:0]  lo_ff, lo_in;
   logic [SAPL_LEN_W-1:0]  hi_ff, hi_in;
   logic [SAPL_ADDR_W-1:0] query_ff, query_in;
   rsp_word_type           result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic                   req_accept;
   logic                   csr_accept;
   logic                   can_emit;
   logic [SAPL_LEN_W-1:0]  eff_len;
   logic [SAPL_LEN_W:0]    probe_sum;
   logic [SAPL_LEN_W-1:0]  mid;
   logic [SAPL_LEN_W-1:0]  mid_inc;
   logic [SAPL_LEN_W-1:0]  pick;
   logic [SAPL_LEN_W-1:0]  read_index;
   logic [IW-1:0]          read_wide;
   logic [IW-1:0]          write_wide;
   logic                   load_in_range;
   logic                   entry_above;
   logic                   tbl_wr_en;
   logic                   tbl_rd_en;
   logic [AW-1:0]          tbl_wr_addr;
   logic [AW-1:0]          tbl_rd_addr;
   logic [SAPL_ADDR_W-1:0] tbl_rd_data;

   // Handshakes.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_accept = csr_valid && csr_ready;
   assign can_emit   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_word_ff;

   // Search bounds and probe positions.
   assign eff_len   = (len_ff > SAPL_LEN_W'(MAX_LEN)) ? SAPL_LEN_W'(MAX_LEN) : len_ff;
   assign probe_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = probe_sum[SAPL_LEN_W:1];
   assign mid_inc   = mid + SAPL_LEN_W'(1);
   assign pick      = (lo_ff == '0) ? '0 : (lo_ff - SAPL_LEN_W'(1));

   // Shared comparator: does the probed entry lie above the query?
   assign entry_above = (tbl_rd_data > query_ff);

   // Table port control.
   assign load_in_range = ({16'b0, req_data.entry_index} < 32'(TABLE_DEPTH));
   assign tbl_wr_en     = req_accept && (req_data.mode == SAPL_MODE_LOAD) && load_in_range;
   assign write_wide    = IW'(req_data.entry_index);
   assign tbl_wr_addr   = write_wide[AW-1:0];
   assign tbl_rd_en     = (state_ff == ST_PROBE) || (state_ff == ST_PICK);
   assign read_index    = (state_ff == ST_PICK) ? pick : mid;
   assign read_wide     = IW'(read_index);
   assign tbl_rd_addr   = read_wide[AW-1:0];

   sapl_table #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (SAPL_ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_data.entry_address),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      query_in     = query_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      // The response register empties when its word is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_accept) begin
         len_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.mode == SAPL_MODE_QUERY)) begin
               query_in = req_data.query_address;
               lo_in    = '0;
               hi_in    = eff_len;
               if (eff_len == '0) begin
                  // Empty table: answer at once against address zero.
                  result_in.symbol_index = '0;
                  result_in.offset       = req_data.query_address;
                  result_in.below_first  = 1'b1;
                  state_in               = ST_EMIT;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (entry_above) begin
               hi_in    = mid;
               state_in = (lo_ff < mid) ? ST_PROBE : ST_PICK;
            end else begin
               lo_in    = mid_inc;
               state_in = (mid_inc < hi_ff) ? ST_PROBE : ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_PICK_DATA;
         end
         ST_PICK_DATA: begin
            result_in.symbol_index = pick[SAPL_INDEX_W-1:0];
            result_in.offset       = query_ff - tbl_rd_data;
            result_in.below_first  = (lo_ff == '0);
            state_in               = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      query_ff    <= query_in;
      result_ff   <= result_in;
      rsp_word_ff <= rsp_word_in;
   end

`ifndef SYNTHESIS
   // A response word appears only as the sequencer leaves its emit step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the emit step");

   // A probe is issued only while the search range is not empty.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (lo_ff < hi_ff))
      else $error("probe issued with an empty search range");

   // The upper search bound never passes the clamped table length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE || state_ff == ST_COMPARE) |-> (hi_ff <= SAPL_LEN_W'(MAX_LEN)))
      else $error("search bound beyond the table");

   // The table is written only while no query is under way.
   assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (state_ff == ST_IDLE))
      else $error("table written during a search");
`endif

endmodule
